@@ design/lj_pkg.sv @@
// ----------------------------------------------------------------------------
// lj_pkg
// Shared types and constants for the Lennard-Jones force accumulator.
// ----------------------------------------------------------------------------
package lj_pkg;

	// coordinate width default and fixed-point layout
	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_W          = 24;
	localparam int FORCE_W        = 48;
	localparam int BIG_D_LOG      = 28;

	// shared multiplier: A operand width, digit width, digit count
	localparam int MUL_A_W  = 49;
	localparam int MUL_DIG  = 16;
	localparam int MUL_NDIG = 4;
	localparam int PROD_W   = MUL_DIG * MUL_NDIG;

	// divider: 2^48 / r2q
	localparam int DIV_Q_W = 49;
	localparam int R2_W    = 58;

	// unsigned Q.16 product clip level is 2^47-1
	localparam int UQ_W = 47;

	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

	// register reset values
	localparam logic [CFG_W-1:0] BOX_RST = 24'd1310720;
	localparam logic [CFG_W-1:0] REP_RST = 24'd31457;
	localparam logic [CFG_W-1:0] ATT_RST = 24'd15729;
	localparam logic [CFG_W-1:0] MIN_RST = 24'd1;

	// register indexes
	typedef enum logic [1:0] {
		REG_BOX = 2'd0,
		REG_REP = 2'd1,
		REG_ATT = 2'd2,
		REG_MIN = 2'd3
	} cfg_reg_t;

	// per-pair classification flags carried through the queue
	typedef struct packed {
		logic pair_valid;
		logic huge;
		logic last;
	} flags_t;

	localparam int FLAGS_W = $bits(flags_t);

endpackage

@@ design/lj_front.sv @@
// ----------------------------------------------------------------------------
// lj_front
// Input stage: minimum-image displacement per axis and pair classification.
// ----------------------------------------------------------------------------
module lj_front #(
	parameter int COORD_BITS = lj_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [COORD_BITS-1:0]       own_x,
	input  logic [COORD_BITS-1:0]       own_y,
	input  logic [COORD_BITS-1:0]       own_z,
	input  logic [COORD_BITS-1:0]       nbr_x,
	input  logic [COORD_BITS-1:0]       nbr_y,
	input  logic [COORD_BITS-1:0]       nbr_z,
	input  logic                        pair_valid,
	input  logic                        last_neighbor,
	input  logic [lj_pkg::CFG_W-1:0]    box_length,
	output logic                        push,
	output logic [3*(COORD_BITS+1)+lj_pkg::FLAGS_W-1:0] push_data,
	input  logic                        queue_full
);

	localparam int DW = COORD_BITS + 1;
	localparam int WW = ((COORD_BITS + 3) > 27) ? (COORD_BITS + 3) : 27;

	logic signed [DW-1:0] d_s1 [0:2];
	lj_pkg::flags_t       flags_s1;
	logic                 valid_s1;
	logic                 take;
	logic signed [DW-1:0] d_nxt [0:2];
	logic                 huge_nxt;

	// single minimum-image wrap against the box
	function automatic logic signed [DW-1:0] wrap_disp(
		input logic [COORD_BITS-1:0] o,
		input logic [COORD_BITS-1:0] n,
		input logic [lj_pkg::CFG_W-1:0] box
	);
		logic signed [WW-1:0] dd;
		logic signed [WW-1:0] twice;
		logic signed [WW-1:0] bx;
		dd = $signed({{(WW-COORD_BITS){1'b0}}, o}) - $signed({{(WW-COORD_BITS){1'b0}}, n});
		twice = dd <<< 1;
		bx = $signed({{(WW-lj_pkg::CFG_W){1'b0}}, box});
		if (twice > bx) begin
			dd = dd - bx;
		end else if (twice < -bx) begin
			dd = dd + bx;
		end
		return dd[DW-1:0];
	endfunction

	// any axis at or beyond 2^28 makes the pair contribute nothing
	function automatic logic is_huge(input logic signed [DW-1:0] d);
		logic signed [63:0] e;
		e = {{(64-DW){d[DW-1]}}, d};
		return (e >= (64'sd1 <<< lj_pkg::BIG_D_LOG)) || (e <= -(64'sd1 <<< lj_pkg::BIG_D_LOG));
	endfunction

	always_comb begin
		d_nxt[0] = wrap_disp(own_x, nbr_x, box_length);
		d_nxt[1] = wrap_disp(own_y, nbr_y, box_length);
		d_nxt[2] = wrap_disp(own_z, nbr_z, box_length);
		huge_nxt = is_huge(d_nxt[0]) || is_huge(d_nxt[1]) || is_huge(d_nxt[2]);
	end

	// stage register drains into the queue
	assign push     = valid_s1 && !queue_full;
	assign take     = !valid_s1 || push;
	assign in_stall = !take;
	assign push_data = {d_s1[2], d_s1[1], d_s1[0], flags_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			d_s1[0]             <= d_nxt[0];
			d_s1[1]             <= d_nxt[1];
			d_s1[2]             <= d_nxt[2];
			flags_s1.pair_valid <= pair_valid;
			flags_s1.huge       <= huge_nxt;
			flags_s1.last       <= last_neighbor;
		end
	end

endmodule

@@ design/lj_queue.sv @@
// ----------------------------------------------------------------------------
// lj_queue
// Small FIFO between the front stage and the force sequencer.
// ----------------------------------------------------------------------------
module lj_queue #(
	parameter int W     = 8,
	parameter int DEPTH = lj_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/lj_mul.sv @@
// ----------------------------------------------------------------------------
// lj_mul
// Shared 49 x 64 multiplier, one 16-bit digit of B per cycle, MSB first.
// Keeps the low 64 product bits and a sticky flag for products >= 2^64.
// ----------------------------------------------------------------------------
module lj_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lj_pkg::MUL_A_W-1:0]  a,
	input  logic [lj_pkg::MUL_A_W-1:0]  b,
	output logic                        done,
	output logic [lj_pkg::PROD_W-1:0]   prod,
	output logic                        big
);

	localparam int PW = lj_pkg::PROD_W;
	localparam int DG = lj_pkg::MUL_DIG;
	localparam int CW = $clog2(lj_pkg::MUL_NDIG);

	logic [lj_pkg::MUL_A_W-1:0]    a_q;
	logic [PW-1:0]                 b_q;
	logic [PW-1:0]                 acc_q;
	logic                          big_q;
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lj_pkg::MUL_A_W+DG-1:0] pp;
	logic [PW+1:0]                 sum;

	// one partial product and accumulate per cycle
	assign pp  = a_q * b_q[PW-1 -: DG];
	assign sum = {2'b00, acc_q[PW-DG-1:0], {DG{1'b0}}} + (PW+2)'(pp);

	assign done = done_q;
	assign prod = acc_q;
	assign big  = big_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(lj_pkg::MUL_NDIG - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(lj_pkg::MUL_NDIG - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= PW'(b);
			acc_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= sum[PW-1:0];
			big_q <= big_q || (|acc_q[PW-1 -: DG]) || (|sum[PW+1:PW]);
			b_q   <= b_q << DG;
		end
	end

endmodule

@@ design/lj_div.sv @@
// ----------------------------------------------------------------------------
// lj_div
// Restoring divider for 2^48 / r2q, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lj_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lj_pkg::R2_W-1:0]     divisor,
	output logic                        done,
	output logic [lj_pkg::DIV_Q_W-1:0]  quot
);

	localparam int QW = lj_pkg::DIV_Q_W;
	localparam int RW = lj_pkg::R2_W;
	localparam int CW = $clog2(QW);

	logic [RW-1:0] div_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW:0]   shifted;
	logic          ge;

	// dividend is a single one in the top quotient position
	assign shifted = {rem_q, (cnt_q == '0)};
	assign ge      = shifted >= {1'b0, div_q};
	assign done    = done_q;
	assign quot    = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(QW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? RW'(shifted - {1'b0, div_q}) : shifted[RW-1:0];
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

endmodule

@@ design/lj_back.sv @@
// ----------------------------------------------------------------------------
// lj_back
// Force sequencer: r2, reciprocal, power chain, per-axis force and
// saturating accumulation, result register.
// ----------------------------------------------------------------------------
module lj_back #(
	parameter int COORD_BITS = lj_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [3*(COORD_BITS+1)+lj_pkg::FLAGS_W-1:0] pop_data,
	input  logic                        queue_empty,
	output logic                        pop,
	input  logic [lj_pkg::CFG_W-1:0]    repulsive_coeff,
	input  logic [lj_pkg::CFG_W-1:0]    attractive_coeff,
	input  logic [lj_pkg::CFG_W-1:0]    min_r2,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [lj_pkg::FORCE_W-1:0] force_x,
	output logic signed [lj_pkg::FORCE_W-1:0] force_y,
	output logic signed [lj_pkg::FORCE_W-1:0] force_z,
	output logic                        saturated
);

	localparam int DW = COORD_BITS + 1;
	localparam int FW = lj_pkg::FORCE_W;
	localparam int UW = lj_pkg::UQ_W;
	localparam int AW = lj_pkg::MUL_A_W;
	localparam int FB = lj_pkg::FRAC_BITS;

	typedef enum logic [2:0] {
		S_POP, S_MUL_GO, S_MUL_WAIT, S_CHECK, S_DIV_GO, S_DIV_WAIT, S_FINISH, S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		ST_SQX, ST_SQY, ST_SQZ, ST_S4, ST_S8, ST_S6, ST_S14, ST_REP, ST_ATT,
		ST_FX, ST_FY, ST_FZ
	} step_t;

	state_t               state_q;
	step_t                step_q;
	logic signed [DW-1:0] d_q [0:2];
	logic                 last_q;
	logic [lj_pkg::R2_W-1:0]    r2q_q;
	logic [lj_pkg::DIV_Q_W-1:0] s2_q;
	logic [UW-1:0]        s4_q, s6_q, s8_q, s14_q, rep_q, att_q;
	logic signed [FW-1:0] sum_q [0:2];
	logic                 clip_q;
	logic                 out_valid_q;
	logic signed [FW-1:0] fx_q, fy_q, fz_q;
	logic                 sat_q;

	lj_pkg::flags_t       in_flags;
	logic [1:0]           ax;
	logic signed [DW-1:0] d_sel;
	logic [DW-1:0]        d_mag;
	logic signed [FW-1:0] f_val;
	logic [UW-1:0]        f_mag;
	logic [AW-1:0]        op_a, op_b;
	logic                 mul_start, mul_done, mul_big;
	logic [lj_pkg::PROD_W-1:0] mul_prod;
	logic                 div_start, div_done;
	logic [lj_pkg::DIV_Q_W-1:0] div_quot;
	logic                 uclip;
	logic [UW-1:0]        uval;
	logic [FW-1:0]        p_mag;
	logic                 neg;
	logic                 sclip;
	logic signed [FW-1:0] comp;
	logic signed [FW:0]   acc_sum;
	logic                 aclip;
	logic signed [FW-1:0] acc_val;
	logic                 skip;
	logic                 emit;

	assign in_flags = pop_data[lj_pkg::FLAGS_W-1:0];

	// axis in use by the current step
	always_comb begin
		unique case (step_q)
			ST_SQX, ST_FX: ax = 2'd0;
			ST_SQY, ST_FY: ax = 2'd1;
			default:       ax = 2'd2;
		endcase
		d_sel = d_q[ax];
		d_mag = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
		f_val = $signed({1'b0, rep_q}) - $signed({1'b0, att_q});
		f_mag = f_val[FW-1] ? UW'(-f_val) : UW'(f_val);
	end

	// multiplier operand select
	always_comb begin
		unique case (step_q)
			ST_SQX, ST_SQY, ST_SQZ: begin op_a = AW'(d_mag);  op_b = AW'(d_mag); end
			ST_S4:  begin op_a = s2_q;              op_b = s2_q;        end
			ST_S8:  begin op_a = AW'(s4_q);         op_b = AW'(s4_q);   end
			ST_S6:  begin op_a = AW'(s4_q);         op_b = s2_q;        end
			ST_S14: begin op_a = AW'(s8_q);         op_b = AW'(s6_q);   end
			ST_REP: begin op_a = AW'(repulsive_coeff);  op_b = AW'(s14_q); end
			ST_ATT: begin op_a = AW'(attractive_coeff); op_b = AW'(s8_q);  end
			default: begin op_a = AW'(f_mag);       op_b = AW'(d_mag);  end
		endcase
	end

	assign mul_start = (state_q == S_MUL_GO);
	assign div_start = (state_q == S_DIV_GO);

	lj_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (mul_prod),
		.big    (mul_big)
	);

	lj_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (r2q_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	// unsigned Q.16 product with clip at 2^47-1
	always_comb begin
		uclip = mul_big || mul_prod[lj_pkg::PROD_W-1];
		uval  = uclip ? {UW{1'b1}} : mul_prod[UW+FB-1:FB];
	end

	// signed force component and saturating accumulate
	always_comb begin
		p_mag = mul_prod[lj_pkg::PROD_W-1:FB];
		neg   = f_val[FW-1] ^ d_sel[DW-1];
		sclip = mul_big || (neg ? (p_mag[FW-1] && (|p_mag[FW-2:0])) : p_mag[FW-1]);
		if (sclip) begin
			comp = neg ? lj_pkg::FORCE_MIN : lj_pkg::FORCE_MAX;
		end else begin
			comp = neg ? -$signed(p_mag) : $signed(p_mag);
		end
		acc_sum = {sum_q[ax][FW-1], sum_q[ax]} + {comp[FW-1], comp};
		aclip   = acc_sum[FW] != acc_sum[FW-1];
		if (aclip) begin
			acc_val = acc_sum[FW] ? lj_pkg::FORCE_MIN : lj_pkg::FORCE_MAX;
		end else begin
			acc_val = acc_sum[FW-1:0];
		end
	end

	assign skip = (r2q_q == '0) ||
		(r2q_q < {{(lj_pkg::R2_W-lj_pkg::CFG_W-FB){1'b0}}, min_r2, {FB{1'b0}}});

	assign pop  = (state_q == S_POP) && !queue_empty;
	assign emit = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign force_x   = fx_q;
	assign force_y   = fy_q;
	assign force_z   = fz_q;
	assign saturated = sat_q;

	// sequencer, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_POP;
			step_q      <= ST_SQX;
			out_valid_q <= 1'b0;
			fx_q        <= '0;
			fy_q        <= '0;
			fz_q        <= '0;
			sat_q       <= 1'b0;
			clip_q      <= 1'b0;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			sum_q[2]    <= '0;
		end else begin
			// result register: load on emit, drop once taken
			if (emit) begin
				out_valid_q <= 1'b1;
				fx_q        <= sum_q[0];
				fy_q        <= sum_q[1];
				fz_q        <= sum_q[2];
				sat_q       <= clip_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_POP: begin
					if (!queue_empty) begin
						step_q <= ST_SQX;
						if (!in_flags.pair_valid || in_flags.huge) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_MUL_GO;
						end
					end
				end
				S_MUL_GO: state_q <= S_MUL_WAIT;
				S_MUL_WAIT: begin
					if (mul_done) begin
						unique case (step_q)
							ST_SQX: begin step_q <= ST_SQY; state_q <= S_MUL_GO; end
							ST_SQY: begin step_q <= ST_SQZ; state_q <= S_MUL_GO; end
							ST_SQZ: state_q <= S_CHECK;
							ST_S4:  begin step_q <= ST_S8;  state_q <= S_MUL_GO; end
							ST_S8:  begin step_q <= ST_S6;  state_q <= S_MUL_GO; end
							ST_S6:  begin step_q <= ST_S14; state_q <= S_MUL_GO; end
							ST_S14: begin step_q <= ST_REP; state_q <= S_MUL_GO; end
							ST_REP: begin step_q <= ST_ATT; state_q <= S_MUL_GO; end
							ST_ATT: begin step_q <= ST_FX;  state_q <= S_MUL_GO; end
							ST_FX:  begin step_q <= ST_FY;  state_q <= S_MUL_GO; end
							ST_FY:  begin step_q <= ST_FZ;  state_q <= S_MUL_GO; end
							default: state_q <= S_FINISH;
						endcase
						unique case (step_q)
							ST_SQX, ST_SQY, ST_SQZ: ;
							ST_S4, ST_S8, ST_S6, ST_S14, ST_REP, ST_ATT: begin
								if (uclip) clip_q <= 1'b1;
							end
							default: begin
								sum_q[ax] <= acc_val;
								if (sclip || aclip) clip_q <= 1'b1;
							end
						endcase
					end
				end
				S_CHECK:    state_q <= skip ? S_FINISH : S_DIV_GO;
				S_DIV_GO:   state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						step_q  <= ST_S4;
						state_q <= S_MUL_GO;
					end
				end
				S_FINISH: state_q <= last_q ? S_EMIT : S_POP;
				S_EMIT: begin
					if (emit) begin
						clip_q      <= 1'b0;
						sum_q[0]    <= '0;
						sum_q[1]    <= '0;
						sum_q[2]    <= '0;
						state_q     <= S_POP;
					end
				end
				default: state_q <= S_POP;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			d_q[0] <= $signed(pop_data[lj_pkg::FLAGS_W +: DW]);
			d_q[1] <= $signed(pop_data[lj_pkg::FLAGS_W+DW +: DW]);
			d_q[2] <= $signed(pop_data[lj_pkg::FLAGS_W+2*DW +: DW]);
			last_q <= in_flags.last;
			r2q_q  <= '0;
		end
		if (state_q == S_MUL_WAIT && mul_done) begin
			unique case (step_q)
				ST_SQX, ST_SQY, ST_SQZ: r2q_q <= r2q_q + mul_prod[lj_pkg::R2_W-1:0];
				ST_S4:  s4_q  <= uval;
				ST_S8:  s8_q  <= uval;
				ST_S6:  s6_q  <= uval;
				ST_S14: s14_q <= uval;
				ST_REP: rep_q <= uval;
				ST_ATT: att_q <= uval;
				default: ;
			endcase
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			s2_q <= div_quot;
		end
	end

endmodule

@@ design/lennard_jones_force_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// lennard_jones_force_accumulator_top
// Lennard-Jones pair force accumulator with minimum-image wrapping.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_stall    own_*, nbr_*, pair_valid, last_neighbor
//  out       out_valid / out_stall  force_x/y/z, saturated
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A computed pair makes twelve passes through the shared multiplier in the
//  back end (49 x 16 bits a cycle) and one pass through the reciprocal
//  divider (49 quotient bits), plus dequeue, floor check and finish. A pair
//  below the distance floor makes the three squares only; an invalid or far
//  pair goes straight from dequeue to finish. A result adds the emit state.
//  The front stage and a 4-entry queue take pairs while the back end works.
//  Reset clears the sums and the register file to its defaults.
//  A stalled result holds in the output register; the next atom proceeds
//  until its own result is ready.
// ----------------------------------------------------------------------------
module lennard_jones_force_accumulator_top #(
	parameter int COORD_BITS = lj_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [COORD_BITS-1:0]       own_x,
	input  logic [COORD_BITS-1:0]       own_y,
	input  logic [COORD_BITS-1:0]       own_z,
	input  logic [COORD_BITS-1:0]       nbr_x,
	input  logic [COORD_BITS-1:0]       nbr_y,
	input  logic [COORD_BITS-1:0]       nbr_z,
	input  logic                        pair_valid,
	input  logic                        last_neighbor,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [lj_pkg::FORCE_W-1:0] force_x,
	output logic signed [lj_pkg::FORCE_W-1:0] force_y,
	output logic signed [lj_pkg::FORCE_W-1:0] force_z,
	output logic                        saturated,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [lj_pkg::CFG_W-1:0]    cfg_data
);

	localparam int QW = 3 * (COORD_BITS + 1) + lj_pkg::FLAGS_W;

	logic [lj_pkg::CFG_W-1:0] box_q, rep_q, att_q, min_q;
	logic          push, pop, q_full, q_empty;
	logic [QW-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= lj_pkg::BOX_RST;
			rep_q <= lj_pkg::REP_RST;
			att_q <= lj_pkg::ATT_RST;
			min_q <= lj_pkg::MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lj_pkg::cfg_reg_t'(cfg_index))
				lj_pkg::REG_BOX: box_q <= cfg_data;
				lj_pkg::REG_REP: rep_q <= cfg_data;
				lj_pkg::REG_ATT: att_q <= cfg_data;
				lj_pkg::REG_MIN: min_q <= cfg_data;
			endcase
		end
	end

	lj_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.own_x         (own_x),
		.own_y         (own_y),
		.own_z         (own_z),
		.nbr_x         (nbr_x),
		.nbr_y         (nbr_y),
		.nbr_z         (nbr_z),
		.pair_valid    (pair_valid),
		.last_neighbor (last_neighbor),
		.box_length    (box_q),
		.push          (push),
		.push_data     (push_data),
		.queue_full    (q_full)
	);

	lj_queue #(.W(QW), .DEPTH(lj_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	lj_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_data         (pop_data),
		.queue_empty      (q_empty),
		.pop              (pop),
		.repulsive_coeff  (rep_q),
		.attractive_coeff (att_q),
		.min_r2           (min_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.force_x          (force_x),
		.force_y          (force_y),
		.force_z          (force_z),
		.saturated        (saturated)
	);

endmodule

@@ design/lj_checker.sv @@
// ----------------------------------------------------------------------------
// lj_checker
// Port-level checks for the force accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module lj_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic signed [lj_pkg::FORCE_W-1:0] force_x,
	input logic signed [lj_pkg::FORCE_W-1:0] force_y,
	input logic signed [lj_pkg::FORCE_W-1:0] force_z,
	input logic                        saturated,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({force_x, force_y, force_z, saturated}))
		else $error("result changed while stalled");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

	// reset leaves no result pending and the input open
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("activity right after reset");

endmodule

bind lennard_jones_force_accumulator_top lj_checker u_lj_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.force_x   (force_x),
	.force_y   (force_y),
	.force_z   (force_z),
	.saturated (saturated),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
